@@ rtl/citation_extract_dedup_core_assert.svh @@
// -----------------------------------------------------------------------------
// citation_extract_dedup_core_assert
// Assertion macros used by the citation scanner core.
// -----------------------------------------------------------------------------
`ifndef CITATION_EXTRACT_DEDUP_CORE_ASSERT_SVH
`define CITATION_EXTRACT_DEDUP_CORE_ASSERT_SVH
// Same-cycle implication checked on every rising clock edge outside reset.
`define CED_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CED_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ rtl/ced_pkg.sv @@
// -----------------------------------------------------------------------------
// ced_pkg
// Shared constants and types of the citation scanner.
// -----------------------------------------------------------------------------
package ced_pkg;
  localparam int TableDepth = 128;
  localparam int NameBytes  = 32;
  localparam int NameMax    = NameBytes - 1;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int LenW       = $clog2(NameBytes);

  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef logic [NameBytes*8-1:0] name_vec_t;

  // Key passed from the controller down the cell chain.
  typedef struct packed {
    logic             valid;
    logic [31:0]      year;
    name_vec_t        name;
  } key_t;
endpackage

@@ rtl/ced_if.sv @@
// -----------------------------------------------------------------------------
// ced_in_if / ced_out_if
// Valid/ready channels of the citation scanner.
// -----------------------------------------------------------------------------
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ced_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         entry_index;
  logic [7:0]         name_char;
  logic signed [31:0] year;
  logic               last;
  modport source (output valid, output entry_index, output name_char,
                  output year, output last, input ready);
  modport sink   (input valid, input entry_index, input name_char,
                  input year, input last, output ready);
endinterface

@@ rtl/citation_extract_dedup_core.sv @@
// -----------------------------------------------------------------------------
// citation_extract_dedup_core
// Citation scanner with a duplicate-free table.
// -----------------------------------------------------------------------------
// One character is accepted per cycle while parsing. A committed reference
// runs its key through a chain of TableDepth cells, one cell per cycle, so the
// input is held after a year ends until the match flag leaves the chain;
// a new pair then emits one beat per name character (one beat for an empty
// name), and the next character waits until the last beat has been taken.
module citation_extract_dedup_core (
  input  logic clk_i,
  input  logic rst_ni,
  ced_in_if.sink    in_if,
  ced_out_if.source out_if
);
  import ced_pkg::*;
  `include "citation_extract_dedup_core_assert.svh"

  localparam logic [2:0] MIdle = 3'd0, MName = 3'd1, MYFirst = 3'd2,
                         MYSpace = 3'd3, MYDigit = 3'd4;
  localparam logic [1:0] PParse = 2'd0, PScan = 2'd1, PEmit = 2'd2;

  logic [2:0]      mode_q, mode_d;
  logic [1:0]      ph_q, ph_d;
  name_vec_t       name_q, name_d;
  logic [LenW-1:0] len_q, len_d;
  logic [31:0]     acc_q, acc_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] wait_q, wait_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            start_q, start_d;
  logic [31:0]     yr_q, yr_d;

  key_t            key [TableDepth+1];
  logic            hit [TableDepth+1];
  logic [TableDepth-1:0] wr;

  logic [7:0] c;
  logic       is_dig, is_sp, fire, ends, emit_done;
  logic [31:0] acc_x10;

  assign c      = in_if.ch;
  assign is_dig = (c >= ChZero) && (c <= ChNine);
  assign is_sp  = (c == ChSpace) || (c == ChTab) || (c == ChLf);
  assign in_if.ready = (ph_q == PParse);
  assign fire   = in_if.valid && in_if.ready;
  assign acc_x10 = (acc_q << 3) + (acc_q << 1);

  // The year ends at this character.
  always_comb begin
    unique case (mode_q)
      MYFirst, MYSpace: ends = !is_sp && (c != ChMinus) && !is_dig;
      MYDigit:          ends = !is_dig;
      default:          ends = 1'b0;
    endcase
  end

  assign key[0].valid = fire && ends;
  assign key[0].year  = neg_q ? (32'd0 - acc_q) : acc_q;
  assign key[0].name  = name_q;
  assign hit[0]       = 1'b0;

  // Chain of table cells.
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    assign wr[g] = (ph_q == PScan) && (wait_q == '0) && !hit[TableDepth] &&
                   (cnt_q == CntW'(g));
    ced_cell u_cell (
      .clk_i, .rst_ni,
      .key_i (g == 0 ? key[0] : key[g]),
      .hit_i (hit[g]),
      .wr_i  (wr[g]),
      .key_o (key[g+1]),
      .hit_o (hit[g+1])
    );
  end

  // Cells store the name that the key carries from name_q; emit_done marks the taken last beat.
  assign emit_done = out_if.valid && out_if.ready && out_if.last;

  // Parser and sequencer.
  always_comb begin
    mode_d = mode_q; ph_d = ph_q; name_d = name_q; len_d = len_q;
    acc_d = acc_q; neg_d = neg_q; cnt_d = cnt_q; wait_d = wait_q;
    pos_d = pos_q; start_d = start_q; yr_d = yr_q;
    unique case (ph_q)
      PParse: begin
        if (fire) begin
          unique case (mode_q)
            MName: begin
              if (c == ChComma) begin
                acc_d = '0; neg_d = 1'b0; mode_d = MYFirst;
              end else if (c == ChNul) begin
                mode_d = MIdle;
              end else if (32'(len_q) < NameMax) begin
                name_d[8*len_q +: 8] = c;
                len_d = len_q + 1'b1;
              end
            end
            MYFirst, MYSpace: begin
              if (is_sp) mode_d = MYSpace;
              else if (c == ChMinus) begin
                neg_d = 1'b1; mode_d = MYDigit;
              end else if (is_dig) begin
                acc_d = {24'd0, c - ChZero}; mode_d = MYDigit;
              end
            end
            MYDigit: begin
              if (is_dig) acc_d = acc_x10 + {24'd0, c - ChZero};
            end
            default: begin
              if (c == ChOpen) begin
                name_d = '0; len_d = '0; mode_d = MName;
              end else begin
                mode_d = MIdle;
              end
            end
          endcase
          if (ends) begin
            ph_d    = PScan;
            wait_d  = CntW'(TableDepth - 1);
            yr_d    = key[0].year;
            start_d = (c == ChOpen) && (mode_q != MYFirst);
          end
        end
      end
      PScan: begin
        if (wait_q != '0) begin
          wait_d = wait_q - 1'b1;
        end else if (hit[TableDepth] || (32'(cnt_q) >= TableDepth)) begin
          ph_d = PParse;
        end else begin
          ph_d = PEmit; pos_d = '0;
        end
        if (ph_d == PParse) begin
          if (start_q) begin
            name_d = '0; len_d = '0; mode_d = MName;
          end else mode_d = MIdle;
        end
      end
      default: begin
        if (out_if.valid && out_if.ready) begin
          pos_d = pos_q + 1'b1;
          if (out_if.last) begin
            cnt_d = cnt_q + 1'b1;
            ph_d  = PParse;
            if (start_q) begin
              name_d = '0; len_d = '0; mode_d = MName;
            end else mode_d = MIdle;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; ph_q <= PParse; name_q <= '0; len_q <= '0;
      acc_q <= '0; neg_q <= 1'b0; cnt_q <= '0; wait_q <= '0;
      pos_q <= '0; start_q <= 1'b0; yr_q <= '0;
    end else begin
      mode_q <= mode_d; ph_q <= ph_d; name_q <= name_d; len_q <= len_d;
      acc_q <= acc_d; neg_q <= neg_d; cnt_q <= cnt_d; wait_q <= wait_d;
      pos_q <= pos_d; start_q <= start_d; yr_q <= yr_d;
    end
  end

  // Output beats straight from held registers.
  assign out_if.valid       = (ph_q == PEmit);
  assign out_if.entry_index = cnt_q[6:0];
  assign out_if.name_char   = (len_q == '0) ? 8'd0 : name_q[8*pos_q +: 8];
  assign out_if.year        = yr_q;
  assign out_if.last        = (len_q == '0) || (pos_q == len_q - 1'b1);

  `CED_ASSERT_IMP(a_no_emit_full, clk_i, rst_ni, out_if.valid,
                  32'(cnt_q) < TableDepth)
  `CED_ASSERT_IMP(a_ready_parse, clk_i, rst_ni, out_if.valid, !in_if.ready)
  `CED_ASSERT_NEXT(a_cnt_step, clk_i, rst_ni, emit_done,
                   cnt_q == $past(cnt_q) + 1'b1)
  `CED_ASSERT_IMP(a_one_write, clk_i, rst_ni, 1'b1, $onehot0(wr))
endmodule

@@ rtl/ced_cell.sv @@
// -----------------------------------------------------------------------------
// ced_cell
// One table slot: holds a stored pair, compares it with the key in the chain.
// -----------------------------------------------------------------------------
module ced_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ced_pkg::key_t key_i,
  input  logic          hit_i,
  input  logic          wr_i,
  output ced_pkg::key_t key_o,
  output logic          hit_o
);
  import ced_pkg::*;

  logic        used_q;
  logic [31:0] year_q;
  name_vec_t   name_q;
  logic        key_valid_q;
  logic [31:0] key_year_q;
  name_vec_t   key_name_q;
  logic        hit_q;

  // A slot stores its pair and is marked used when the controller writes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (wr_i) begin
      used_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      year_q <= key_i.year;
      name_q <= key_i.name;
    end
  end

  // The key moves one cell on per cycle with its running match flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      key_valid_q <= key_i.valid;
      hit_q       <= hit_i | (key_i.valid & used_q & (year_q == key_i.year) &
                              (name_q == key_i.name));
    end
  end

  always_ff @(posedge clk_i) begin
    key_year_q <= key_i.year;
    key_name_q <= key_i.name;
  end

  assign key_o = {key_valid_q, key_year_q, key_name_q};
  assign hit_o = hit_q;
endmodule

@@ sim/tb_citation_extract_dedup_core.sv @@
// -----------------------------------------------------------------------------
// tb_citation_extract_dedup_core
// Self-checking bench for the citation scanner with a duplicate-free table.
// -----------------------------------------------------------------------------
// A queue of characters feeds a clocked driver. A scanner model tracks the
// parse state and the table of stored pairs, and it queues the beats that
// each accepted character should cause. A clocked monitor compares every
// output beat with the oldest queued beat, field by field.
module tb_citation_extract_dedup_core;
  import ced_pkg::*;

  typedef enum logic [2:0] {
    PM_IDLE, PM_NAME, PM_YFIRST, PM_YSPACE, PM_YDIGIT
  } parse_mode_e;

  typedef struct packed {
    logic [6:0]  entry_index;
    logic [7:0]  name_char;
    logic [31:0] year;
    logic        last;
  } ref_beat_t;

  logic clk_i;
  logic rst_ni;

  ced_in_if  in_if ();
  ced_out_if out_if ();

  citation_extract_dedup_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Scanner model state.
  parse_mode_e mdl_mode;
  logic [7:0]  mdl_name [NameBytes];
  int unsigned mdl_len;
  logic [31:0] mdl_acc;
  logic        mdl_neg;
  name_vec_t   tbl_names [$];
  logic [31:0] tbl_years [$];

  logic [7:0]  char_queue [$];
  ref_beat_t   beat_queue [$];

  int          errors = 0;
  int          beats_seen = 0;
  int          chars_sent = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic name_vec_t pack_name();
    name_vec_t v;
    v = '0;
    for (int i = 0; i < NameBytes; i++) v[i*8 +: 8] = mdl_name[i];
    return v;
  endfunction

  // Looks up the pending pair and queues its beats when it is new and the table has room.
  task automatic commit_reference();
    logic [31:0] yr;
    name_vec_t   nm;
    int          n;
    ref_beat_t   b;
    yr = mdl_neg ? (32'd0 - mdl_acc) : mdl_acc;
    nm = pack_name();
    foreach (tbl_years[i]) if (tbl_years[i] == yr && tbl_names[i] == nm) return;
    if (tbl_years.size() >= TableDepth) return;
    n = (mdl_len != 0) ? int'(mdl_len) : 1;
    for (int k = 0; k < n; k++) begin
      b.entry_index = 7'(tbl_years.size());
      b.name_char   = (mdl_len != 0) ? mdl_name[k] : ChNul;
      b.year        = yr;
      b.last        = (k == n - 1);
      beat_queue.push_back(b);
    end
    tbl_names.push_back(nm);
    tbl_years.push_back(yr);
  endtask

  task automatic open_name();
    foreach (mdl_name[i]) mdl_name[i] = ChNul;
    mdl_len  = 0;
    mdl_mode = PM_NAME;
  endtask

  // Advances the scanner model by one accepted character.
  task automatic scan_char(input logic [7:0] c);
    bit          dig;
    bit          spc;
    parse_mode_e prev;
    dig = (c >= ChZero && c <= ChNine);
    spc = (c == ChSpace || c == ChTab || c == ChLf);
    case (mdl_mode)
      PM_NAME: begin
        if (c == ChComma) begin
          mdl_acc  = '0;
          mdl_neg  = 1'b0;
          mdl_mode = PM_YFIRST;
        end else if (c == ChNul) begin
          mdl_mode = PM_IDLE;
        end else if (mdl_len < NameMax) begin
          mdl_name[mdl_len] = c;
          mdl_len++;
        end
        return;
      end
      PM_YFIRST, PM_YSPACE: begin
        if (spc) begin
          mdl_mode = PM_YSPACE;
          return;
        end
        if (c == ChMinus) begin
          mdl_neg  = 1'b1;
          mdl_mode = PM_YDIGIT;
          return;
        end
        if (dig) begin
          mdl_acc  = 32'(c - ChZero);
          mdl_mode = PM_YDIGIT;
          return;
        end
      end
      PM_YDIGIT: begin
        if (dig) begin
          mdl_acc = mdl_acc * 32'd10 + 32'(c - ChZero);
          return;
        end
      end
      default: begin
        if (c == ChOpen) open_name();
        else mdl_mode = PM_IDLE;
        return;
      end
    endcase
    // The year has ended at this character.
    prev = mdl_mode;
    commit_reference();
    if (c == ChOpen && prev != PM_YFIRST) open_name();
    else mdl_mode = PM_IDLE;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
  endtask

  task automatic push_chars(input int n);
    for (int i = 0; i < n; i++) char_queue.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random name drawn mostly from a small alphabet so duplicates occur.
  task automatic push_name();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 40) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) char_queue.push_back(8'($urandom_range(1, 255)));
      else char_queue.push_back(8'(8'h61 + $urandom_range(0, 2)));
    end
  endtask

  task automatic push_year();
    int n;
    if ($urandom_range(0, 3) == 0) char_queue.push_back(ChSpace);
    if ($urandom_range(0, 5) == 0) char_queue.push_back(ChMinus);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 2);
    for (int i = 0; i < n; i++) char_queue.push_back(8'(ChZero + $urandom_range(0, 9)));
  endtask

  // Random well-formed references with an assortment of terminators.
  task automatic push_reference();
    char_queue.push_back(ChOpen);
    push_name();
    if ($urandom_range(0, 15) == 0) begin
      char_queue.push_back(ChNul);
      return;
    end
    char_queue.push_back(ChComma);
    push_year();
    case ($urandom_range(0, 4))
      0: char_queue.push_back(ChNul);
      1: char_queue.push_back(ChMinus);
      2: char_queue.push_back(8'h29);
      default: ; // the next reference's parenthesis ends the year
    endcase
  endtask

  // Driver: offers the head of the character queue and holds it until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.ch    <= '0;
      mdl_mode    = PM_IDLE;
      mdl_len     = 0;
      mdl_acc     = '0;
      mdl_neg     = 1'b0;
      foreach (mdl_name[i]) mdl_name[i] = ChNul;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_char(in_if.ch);
        void'(char_queue.pop_front());
        chars_sent++;
      end
      if (in_if.valid && !in_if.ready) begin
        // The waiting beat stays on the bus unchanged.
      end else if (char_queue.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.ch    <= char_queue[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every output beat against the oldest expected beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        beats_seen++;
        if (beat_queue.size() == 0) begin
          report_mismatch("output beat with nothing expected");
        end else begin
          ref_beat_t e;
          e = beat_queue.pop_front();
          if (out_if.entry_index !== e.entry_index)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      out_if.entry_index, e.entry_index));
          if (out_if.name_char !== e.name_char)
            report_mismatch($sformatf("name_char %02h, expected %02h",
                                      out_if.name_char, e.name_char));
          if (out_if.year !== e.year)
            report_mismatch($sformatf("year %0d, expected %0d",
                                      out_if.year, $signed(e.year)));
          if (out_if.last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_if.last, e.last));
        end
      end
      out_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off  = 1'b0;
    hold_done = 1'b1;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("Timeout with %0d characters queued", char_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain_queue();
    while (char_queue.size() != 0 || in_if.valid) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 74;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed text: empty name, long name, paren in name, negative and
    // overflowing years, paren right after comma, end of text cases.
    push_text("(,1)");
    push_text("(abcdefghijklmnopqrstuvwxyz0123456789,2000 ");
    push_text("(a(b, -12(x,(");
    push_text("(q,99999999999-(q,");
    char_queue.push_back(ChNul);
    push_text("(n");
    char_queue.push_back(ChNul);
    char_queue.push_back(8'hff);
    push_text("(\t,\n\t 7x(,1)");
    push_text("(a(b, -12.");

    // Random text, mostly well-formed references.
    repeat (14) begin
      if ($urandom_range(0, 4) == 0) push_chars($urandom_range(1, 4));
      else push_reference();
    end
    drain_queue();

    // Receiver holds off while the sender keeps offering.
    send_idle_pct = 0;
    push_text("(long1,1(long2,2(long3,3(long4,4");
    char_queue.push_back(ChNul);
    hold_go = 1'b1;
    wait (hold_done);

    send_idle_pct = 74;
    recv_idle_pct = 30;
    repeat (10) push_reference();
    drain_queue();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) push_reference();
    char_queue.push_back(ChNul);
    drain_queue();

    while (beat_queue.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 40) @(posedge clk_i);

    $display("Sent %0d characters, checked %0d beats, table holds %0d pairs.",
             chars_sent, beats_seen, tbl_years.size());
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ced_pkg.sv
rtl/ced_if.sv
rtl/ced_cell.sv
rtl/citation_extract_dedup_core.sv
sim/tb_citation_extract_dedup_core.sv
